[hdl/esm_pkg.sv]
// Shared types and constants of the encoder speed meter.
package esm_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned SCALE_W        = 10;
  localparam int unsigned RAW_W          = 24;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned MAG_W          = SUM_W - 1;
  localparam int unsigned FILT_W         = 32;
  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned PROD_W         = POS_W + SCALE_W + 1;
  localparam int unsigned WINDOW_DEFAULT = 100;

  localparam logic [SCALE_W-1:0]  SCALE_RESET = 10'd15;
  localparam logic [SAMPLE_W-1:0] HALF_RANGE  = 16'h7FFF;
  localparam int                  RAW_MAX     = 8388607;
  localparam int                  RAW_MIN     = -8388608;

  typedef struct packed {
    logic [SAMPLE_W-1:0] counter_sample;
    logic                measure;
  } sample_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic                     speed_valid;
    logic signed [RAW_W-1:0]  raw_speed;
    logic signed [FILT_W-1:0] filtered_speed;
  } result_item_t;

  // Position stage: extended position and change since the last measure.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    measure;
    logic signed [POS_W-1:0] delta;
  } trk_item_t;

  // Speed stage: saturated raw speed.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    measure;
    logic signed [RAW_W-1:0] raw;
  } spd_item_t;

  // Window stage: running sum after this item.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    measure;
    logic signed [RAW_W-1:0] raw;
    logic                    filling;
    logic signed [SUM_W-1:0] sum;
  } win_item_t;

  // Averaging stage: magnitude of the sum and its estimated quotient.
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    measure;
    logic signed [RAW_W-1:0] raw;
    logic                    filling;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        quot;
  } avg_item_t;

endpackage

[hdl/esm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module esm_ram #(
  parameter int unsigned WIDTH = esm_pkg::RAW_W,
  parameter int unsigned DEPTH = esm_pkg::WINDOW_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/esm_track.sv]
// Position extension, measurement delta and scaled, saturated raw speed.
module esm_track (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ld_trk,
  input  esm_pkg::sample_item_t             sample,
  input  logic                              ld_spd,
  input  logic [esm_pkg::SCALE_W-1:0]       scale,
  output esm_pkg::spd_item_t                spd_item
);

  logic [esm_pkg::SAMPLE_W-1:0]     prev_sample;
  logic [esm_pkg::SAMPLE_W-1:0]     wrap_count;
  logic [esm_pkg::SAMPLE_W-1:0]     wrap_count_next;
  logic [esm_pkg::POS_W-1:0]        last_pos;
  logic [esm_pkg::SAMPLE_W-1:0]     up_gap;
  logic [esm_pkg::SAMPLE_W-1:0]     down_gap;
  logic [esm_pkg::POS_W-1:0]        pos_next;
  esm_pkg::trk_item_t               trk_item;
  logic signed [esm_pkg::PROD_W-1:0] prod;
  logic signed [esm_pkg::RAW_W-1:0]  raw_sat;

  always_comb begin
    up_gap   = sample.counter_sample - prev_sample;
    down_gap = prev_sample - sample.counter_sample;
    if (sample.counter_sample > prev_sample && up_gap > esm_pkg::HALF_RANGE) begin
      wrap_count_next = wrap_count - 1'b1;
    end else if (prev_sample > sample.counter_sample && down_gap > esm_pkg::HALF_RANGE) begin
      wrap_count_next = wrap_count + 1'b1;
    end else begin
      wrap_count_next = wrap_count;
    end
    pos_next = {wrap_count_next, sample.counter_sample};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      wrap_count  <= '0;
      last_pos    <= '0;
    end else if (ld_trk) begin
      prev_sample <= sample.counter_sample;
      wrap_count  <= wrap_count_next;
      if (sample.measure) begin
        last_pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_trk) begin
      trk_item.position <= pos_next;
      trk_item.measure  <= sample.measure;
      trk_item.delta    <= pos_next - last_pos;
    end
  end

  // Scale the delta and clamp to the raw speed range.
  always_comb begin
    prod = trk_item.delta * $signed({1'b0, scale});
    if (prod > $signed(esm_pkg::PROD_W'(esm_pkg::RAW_MAX))) begin
      raw_sat = esm_pkg::RAW_W'(esm_pkg::RAW_MAX);
    end else if (prod < $signed(esm_pkg::PROD_W'(esm_pkg::RAW_MIN))) begin
      raw_sat = esm_pkg::RAW_W'(esm_pkg::RAW_MIN);
    end else begin
      raw_sat = prod[esm_pkg::RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_spd) begin
      spd_item.position <= trk_item.position;
      spd_item.measure  <= trk_item.measure;
      spd_item.raw      <= raw_sat;
    end
  end

endmodule

[hdl/esm_window.sv]
// Ring store of recent raw speeds and the running sum over the window.
module esm_window #(
  parameter int unsigned WINDOW = esm_pkg::WINDOW_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ld_win,
  input  esm_pkg::spd_item_t spd_item,
  output esm_pkg::win_item_t win_item
);

  localparam int unsigned PW = $clog2(WINDOW);

  logic [PW-1:0]                    pointer;
  logic [PW-1:0]                    pointer_next;
  logic                             full;
  logic signed [esm_pkg::SUM_W-1:0] sum;
  logic signed [esm_pkg::SUM_W-1:0] sum_next;
  logic [esm_pkg::RAW_W-1:0]        oldest;
  logic signed [esm_pkg::SUM_W-1:0] oldest_ext;
  logic signed [esm_pkg::SUM_W-1:0] raw_ext;
  logic                             take;

  // Read at the next pointer so the oldest entry is ready for a following item.
  esm_ram #(
    .WIDTH (esm_pkg::RAW_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (take),
    .waddr (pointer),
    .wdata (spd_item.raw),
    .raddr (pointer_next),
    .rdata (oldest)
  );

  always_comb begin
    take       = ld_win && spd_item.measure;
    oldest_ext = {{(esm_pkg::SUM_W - esm_pkg::RAW_W){oldest[esm_pkg::RAW_W-1]}}, oldest};
    raw_ext    = {{(esm_pkg::SUM_W - esm_pkg::RAW_W){spd_item.raw[esm_pkg::RAW_W-1]}},
                  spd_item.raw};
    if (full) begin
      sum_next = sum - oldest_ext + raw_ext;
    end else begin
      sum_next = sum + raw_ext;
    end
    if (!take) begin
      pointer_next = pointer;
    end else if (pointer == PW'(WINDOW - 1)) begin
      pointer_next = '0;
    end else begin
      pointer_next = pointer + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer <= '0;
      full    <= 1'b0;
      sum     <= '0;
    end else if (take) begin
      pointer <= pointer_next;
      sum     <= sum_next;
      if (pointer == PW'(WINDOW - 1)) begin
        full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_win) begin
      win_item.position <= spd_item.position;
      win_item.measure  <= spd_item.measure;
      win_item.raw      <= spd_item.raw;
      win_item.filling  <= !full;
      win_item.sum      <= sum_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) pointer <= PW'(WINDOW - 1))
    else $error("ring pointer beyond window");
  assert property (@(posedge clk) disable iff (rst) full |=> full)
    else $error("window full flag dropped");
  assert property (@(posedge clk) disable iff (rst) !take |=> $stable(sum))
    else $error("running sum moved without a measurement");
`endif

endmodule

[hdl/esm_avg.sv]
// Window average: reciprocal multiply, remainder correction and result register.
module esm_avg #(
  parameter int unsigned WINDOW = esm_pkg::WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  ld_avg,
  input  esm_pkg::win_item_t    win_item,
  input  logic                  ld_res,
  output esm_pkg::result_item_t result
);

  localparam int unsigned MAG_W      = esm_pkg::MAG_W;
  localparam int unsigned RW         = $clog2(WINDOW);
  localparam int unsigned SHIFT      = MAG_W + $clog2(WINDOW);
  localparam logic [63:0] RecipWide  =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [31:0] Recip      = RecipWide[31:0];

  logic [esm_pkg::FRAC_BITS-1:0]    frac_table [WINDOW];
  logic [esm_pkg::SUM_W-1:0]        abs_sum;
  logic [MAG_W+31:0]                q_prod;
  esm_pkg::avg_item_t               avg_item;
  logic [MAG_W-1:0]                 prod_w;
  logic [MAG_W-1:0]                 rem;
  logic [MAG_W-1:0]                 rem_c;
  logic [MAG_W-1:0]                 quot_c;
  logic [esm_pkg::FILT_W-1:0]       mag_q;
  logic signed [esm_pkg::FILT_W-1:0] avg_val;
  logic signed [esm_pkg::FILT_W-1:0] filt;

  // Fraction bits of remainder / window.
  for (genvar i = 0; i < WINDOW; i++) begin : g_frac
    localparam int unsigned Frac = ((2 ** esm_pkg::FRAC_BITS) * i) / WINDOW;
    assign frac_table[i] = Frac[esm_pkg::FRAC_BITS-1:0];
  end

  always_comb begin
    abs_sum = win_item.sum[esm_pkg::SUM_W-1] ? -win_item.sum : win_item.sum;
    q_prod  = abs_sum[MAG_W-1:0] * Recip;
  end

  always_ff @(posedge clk) begin
    if (ld_avg) begin
      avg_item.position <= win_item.position;
      avg_item.measure  <= win_item.measure;
      avg_item.raw      <= win_item.raw;
      avg_item.filling  <= win_item.filling;
      avg_item.neg      <= win_item.sum[esm_pkg::SUM_W-1];
      avg_item.mag      <= abs_sum[MAG_W-1:0];
      avg_item.quot     <= MAG_W'(q_prod >> SHIFT);
    end
  end

  // The quotient reaches 2^23 for a window of full negative speed, so keep
  // its bit 23 and let the negation land on the most negative value.
  always_comb begin
    prod_w = MAG_W'(avg_item.quot * WINDOW);
    rem    = avg_item.mag - prod_w;
    if (rem >= MAG_W'(WINDOW)) begin
      quot_c = avg_item.quot + 1'b1;
      rem_c  = rem - MAG_W'(WINDOW);
    end else begin
      quot_c = avg_item.quot;
      rem_c  = rem;
    end
    mag_q   = {quot_c[esm_pkg::FILT_W-esm_pkg::FRAC_BITS-1:0], frac_table[rem_c[RW-1:0]]};
    avg_val = avg_item.neg ? $signed(-mag_q) : $signed(mag_q);
    if (!avg_item.measure) begin
      filt = '0;
    end else if (avg_item.filling) begin
      filt = {avg_item.raw, {esm_pkg::FRAC_BITS{1'b0}}};
    end else begin
      filt = avg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_res) begin
      result.position       <= avg_item.position;
      result.speed_valid    <= avg_item.measure;
      result.raw_speed      <= avg_item.measure ? avg_item.raw : '0;
      result.filtered_speed <= filt;
    end
  end

endmodule

[hdl/encoder_speed_meter.sv]
// Top level of the encoder speed meter: handshakes, stage valids, scale register.
//
//   channel   dir  handshake                       payload
//   sample    in   sample_valid / sample_ready     esm_pkg::sample_item_t
//   result    out  result_valid / result_ready     esm_pkg::result_item_t
//   scale     in   scale_we (no wait)              scale_wdata[9:0]
//
// One item per cycle sustained while results are taken; each item passes through
// registers for position, speed, window sum, quotient, then result.
// Position tracking and the running sum with the ring pointer each compute
// their next state combinationally and register it for the next item.
// rst is synchronous: it clears the stage valids, position tracking, the sum,
// the ring pointer and fill flag, and sets the scale to 15. The ring store is
// not cleared; no entry is used before the ring has been filled once.
// Each stage moves on whenever the stage after it has room, so sample_ready
// stays high while bubbles remain, even with a result held at the output.
module encoder_speed_meter #(
  parameter int unsigned WINDOW = esm_pkg::WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  input  esm_pkg::sample_item_t        sample,
  output logic                         result_valid,
  input  logic                         result_ready,
  output esm_pkg::result_item_t        result,
  input  logic                         scale_we,
  input  logic [esm_pkg::SCALE_W-1:0]  scale_wdata
);

  logic [esm_pkg::SCALE_W-1:0] scale;
  esm_pkg::spd_item_t          spd_item;
  esm_pkg::win_item_t          win_item;

  logic v_trk, v_spd, v_win, v_avg;
  logic rdy_spd, rdy_win, rdy_avg, rdy_res;
  logic ld_trk, ld_spd, ld_win, ld_avg, ld_res;

  // Room in each stage: empty, or its item leaves this cycle.
  always_comb begin
    rdy_res      = !result_valid || result_ready;
    rdy_avg      = !v_avg || rdy_res;
    rdy_win      = !v_win || rdy_avg;
    rdy_spd      = !v_spd || rdy_win;
    sample_ready = !v_trk || rdy_spd;
    ld_trk       = sample_valid && sample_ready;
    ld_spd       = v_trk && rdy_spd;
    ld_win       = v_spd && rdy_win;
    ld_avg       = v_win && rdy_avg;
    ld_res       = v_avg && rdy_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_trk        <= 1'b0;
      v_spd        <= 1'b0;
      v_win        <= 1'b0;
      v_avg        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v_trk        <= ld_trk || (v_trk && !ld_spd);
      v_spd        <= ld_spd || (v_spd && !ld_win);
      v_win        <= ld_win || (v_win && !ld_avg);
      v_avg        <= ld_avg || (v_avg && !ld_res);
      result_valid <= ld_res || (result_valid && !result_ready);
    end
  end

  // Hold the scale; the user must write it only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= esm_pkg::SCALE_RESET;
    end else if (scale_we) begin
      scale <= scale_wdata;
    end
  end

  esm_track u_track (
    .clk      (clk),
    .rst      (rst),
    .ld_trk   (ld_trk),
    .sample   (sample),
    .ld_spd   (ld_spd),
    .scale    (scale),
    .spd_item (spd_item)
  );

  esm_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .ld_win   (ld_win),
    .spd_item (spd_item),
    .win_item (win_item)
  );

  esm_avg #(
    .WINDOW (WINDOW)
  ) u_avg (
    .clk      (clk),
    .ld_avg   (ld_avg),
    .win_item (win_item),
    .ld_res   (ld_res),
    .result   (result)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) !result_valid |-> sample_ready)
    else $error("input stalled with an empty result register");
  assert property (@(posedge clk) disable iff (rst)
      result_valid && !result.speed_valid |->
      result.raw_speed == '0 && result.filtered_speed == '0)
    else $error("speed fields set without a measurement");
  assert property (@(posedge clk) disable iff (rst)
      v_trk && v_spd && v_win && v_avg && result_valid && !result_ready |-> !sample_ready)
    else $error("item taken into a full pipeline");
`endif

endmodule

[verif/encoder_speed_meter_tb.sv]
// Self-checking testbench of the encoder speed meter: predicted readings against the block.
module encoder_speed_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW        = esm_pkg::WINDOW_DEFAULT;
  localparam int MAX_REPORTS   = 10;
  localparam int TAIL_CYCLES   = 10;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 275;
  localparam int MAX_GAP       = 16;

  // Predictor of the block and store of the readings it still owes.
  class speed_meter_scoreboard;
    logic [esm_pkg::SCALE_W-1:0]  scale;
    logic [esm_pkg::SAMPLE_W-1:0] last_sample;
    logic [esm_pkg::SAMPLE_W-1:0] wraps;
    logic [esm_pkg::POS_W-1:0]    measured_pos;
    int                           speed_ring [WINDOW];
    int                           ring_fill;
    int                           ring_ptr;
    longint                       speed_sum;
    esm_pkg::result_item_t        pending_readings [$];
    int                           errors;

    function new();
      scale        = esm_pkg::SCALE_RESET;
      last_sample  = '0;
      wraps        = '0;
      measured_pos = '0;
      ring_fill    = 0;
      ring_ptr     = 0;
      speed_sum    = 0;
      errors       = 0;
      foreach (speed_ring[i]) speed_ring[i] = 0;
    endfunction

    function void set_scale(logic [esm_pkg::SCALE_W-1:0] value);
      scale = value;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // Work out the reading that an accepted sample item causes.
    function void predict_reading(esm_pkg::sample_item_t item);
      logic [esm_pkg::SAMPLE_W-1:0]     s;
      logic [esm_pkg::POS_W-1:0]        pos;
      logic signed [esm_pkg::POS_W-1:0] delta;
      longint                           raw;
      longint                           filt;
      esm_pkg::result_item_t            want;
      s = item.counter_sample;
      // A jump of more than half range is a wrap of the counter.
      if (s > last_sample && (s - last_sample) > esm_pkg::HALF_RANGE) begin
        wraps = wraps - 1'b1;
      end else if (last_sample > s && (last_sample - s) > esm_pkg::HALF_RANGE) begin
        wraps = wraps + 1'b1;
      end
      last_sample = s;
      pos = {wraps, s};
      want = '0;
      want.position = pos;
      if (item.measure) begin
        delta = pos - measured_pos;
        raw = longint'(delta) * longint'(scale);
        if (raw > esm_pkg::RAW_MAX) raw = esm_pkg::RAW_MAX;
        if (raw < esm_pkg::RAW_MIN) raw = esm_pkg::RAW_MIN;
        measured_pos = pos;
        if (ring_fill < WINDOW) begin
          // Still filling: hand back the current speed.
          speed_sum += raw;
          ring_fill++;
          filt = raw * 256;
        end else begin
          speed_sum = speed_sum - longint'(speed_ring[ring_ptr]) + raw;
          filt = (speed_sum * 256) / WINDOW;
        end
        speed_ring[ring_ptr] = int'(raw);
        ring_ptr = (ring_ptr + 1 >= WINDOW) ? 0 : ring_ptr + 1;
        want.speed_valid    = 1'b1;
        want.raw_speed      = raw[esm_pkg::RAW_W-1:0];
        want.filtered_speed = filt[esm_pkg::FILT_W-1:0];
      end
      pending_readings.push_back(want);
    endfunction

    // Compare an accepted result with the oldest reading owed.
    function void check_result(esm_pkg::result_item_t got);
      esm_pkg::result_item_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: pos %0d valid %0b raw %0d filt %0d",
                   got.position, got.speed_valid, got.raw_speed, got.filtered_speed);
        return;
      end
      want = pending_readings.pop_front();
      if (got.position !== want.position || got.speed_valid !== want.speed_valid ||
          got.raw_speed !== want.raw_speed || got.filtered_speed !== want.filtered_speed) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: pos %0d/%0d valid %0b/%0b raw %0d/%0d filt %0d/%0d (exp/act)",
                   want.position, got.position, want.speed_valid, got.speed_valid,
                   want.raw_speed, got.raw_speed, want.filtered_speed, got.filtered_speed);
      end
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        sample_valid = 1'b0;
  logic                        sample_ready;
  esm_pkg::sample_item_t       sample       = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  esm_pkg::result_item_t       result;
  logic                        scale_we     = 1'b0;
  logic [esm_pkg::SCALE_W-1:0] scale_wdata  = '0;

  speed_meter_scoreboard meter;

  // Stretches with no idling come and go at random on each side.
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  // Counter value that the random walk has reached.
  logic [esm_pkg::SAMPLE_W-1:0] walk_value = '0;

  encoder_speed_meter #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .scale_we    (scale_we),
    .scale_wdata (scale_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one sample item after a random pause and hold it until taken.
  // Outputs are read straight after the edge, so they still carry the values
  // the block saw at that edge.
  task automatic send_sample(input logic [esm_pkg::SAMPLE_W-1:0] value, input logic meas);
    int                    gap;
    esm_pkg::sample_item_t item;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    item.counter_sample = value;
    item.measure        = meas;
    // Drop valid only when a pause follows; otherwise keep it high.
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= item;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    meter.predict_reading(item);
  endtask

  // Take results for ever, stalling before each one at random.
  task automatic take_results();
    int gap;
    forever begin
      if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      meter.check_result(result);
    end
  endtask

  // Stop offering items and hold until every owed reading has come back.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (meter.pending() != 0) @(posedge clk);
  endtask

  // Write the scale only with the block idle.
  task automatic write_scale(input logic [esm_pkg::SCALE_W-1:0] value);
    wait_drained();
    scale_we    <= 1'b1;
    scale_wdata <= value;
    @(posedge clk);
    scale_we    <= 1'b0;
    meter.set_scale(value);
  endtask

  // Advance the random walk: mostly steady motion, some jumps right at half
  // range (either side of the wrap threshold), some large steps and noise.
  task automatic send_random_sample();
    int unsigned mode;
    logic        meas;
    mode = $urandom_range(0, 99);
    if (mode < 55) begin
      walk_value = walk_value + 16'($urandom_range(0, 600)) - 16'd300;
    end else if (mode < 70) begin
      walk_value = walk_value + 16'h7FFE + 16'($urandom_range(0, 3));
    end else if (mode < 85) begin
      walk_value = walk_value + 16'($urandom_range(0, 16'hE000)) - 16'h7000;
    end else begin
      walk_value = 16'($urandom);
    end
    meas = ($urandom_range(0, 4) < 2);
    send_sample(walk_value, meas);
  endtask

  initial begin
    logic [esm_pkg::SCALE_W-1:0] phase_scale;
    meter = new();

    // Hold reset, then release it and start the result side.
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none

    // Reset scale of 15. The first sample above half range reads as a wrap
    // from zero and drives the wrap count below zero; then cross back, sit
    // exactly on half range, and wrap on unmeasured ticks.
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0001, 1'b1);

    // Largest scale: clamp at both ends, then step up to just below the clamp.
    write_scale(10'd1023);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0008, 1'b1);
    send_sample(16'h2008, 1'b1);
    send_sample(16'h4009, 1'b1);
    send_sample(16'h6011, 1'b1);

    // Zero scale gives no speed at all.
    write_scale(10'd0);
    send_sample(16'hABCD, 1'b1);
    send_sample(16'h1234, 1'b1);
    walk_value = 16'h1234;

    // Random phases, each under its own scale; the ring fills during the
    // first and the averaged path runs from then on.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_scale = 10'd1023;
        1:       phase_scale = 10'd1;
        3:       phase_scale = 10'd0;
        5:       phase_scale = esm_pkg::SCALE_RESET;
        default: phase_scale = esm_pkg::SCALE_W'($urandom_range(1, 1022));
      endcase
      write_scale(phase_scale);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_sample();
    end

    // Drain, let any stray result show itself, then give the verdict.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (meter.errors == 0 && meter.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // End a run that hangs well past the slowest correct one.
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
